[hw/rtl/itda_pkg.sv]
// package for the integer to decimal ascii unit
// holds the sequencer state type and the character constants, no dependencies
`default_nettype none

package itda_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int CHAR_BITS      = 7;

    localparam logic [CHAR_BITS-1:0] DIGIT_BASE = 7'h30;
    localparam logic [CHAR_BITS-1:0] MINUS_CHAR = 7'h2d;
    localparam logic [3:0]           DIGIT_MAX  = 4'd9;
    localparam logic [3:0]           ADD3_MIN   = 4'd5;
    localparam logic [3:0]           ADD3_VAL   = 4'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_DIGIT
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/int_to_decimal_ascii_unit.sv]
// integer to decimal ascii unit, top level
// shift-and-add-3 converter with a character sequencer, depends on itda_pkg
`default_nettype none

// Converts a signed integer of VALUE_BITS bits into its decimal ASCII text, one
// character per output item, most significant first, with o_last_char on the final
// character. Negative values start with '-', zero gives "0", and the most negative
// value converts correctly through its unsigned magnitude. A single add-3 and shift
// unit runs once per magnitude bit, then the sequencer emits the sign if any and
// steps through every decimal digit position, skipping leading zeros without
// output; it waits before each character while the output side stalls. o_stall is high for the
// whole time an item is in work; the last character sits in an output register so the
// next item can be taken meanwhile.

module int_to_decimal_ascii_unit
    import itda_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_stall,
    input  wire  [VALUE_BITS-1:0]      i_value,
    output logic                       o_valid,
    input  wire                        i_stall,
    output logic [CHAR_BITS-1:0]       o_character,
    output logic                       o_last_char
);

    localparam int ND = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BW = 4 * ND;
    localparam int CW = $clog2(VALUE_BITS);
    localparam int DW = $clog2(ND);

    t_state                r_state, n_state;
    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic [BW-1:0]         r_bcd, n_bcd;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [DW-1:0]         r_dig, n_dig;
    logic                  r_neg, n_neg;
    logic                  r_started, n_started;
    logic                  r_ovalid, n_ovalid;
    logic [CHAR_BITS-1:0]  r_char, n_char;
    logic                  r_last, n_last;

    logic [BW-1:0]         w_adj;
    logic [3:0]            w_top;
    logic                  w_free;
    logic                  w_is_last;
    logic                  w_accept;

    assign w_accept    = i_valid && !o_stall;
    assign w_free      = !r_ovalid || !i_stall;
    assign w_top       = r_bcd[BW-1 -: 4];
    assign w_is_last   = (r_dig == DW'(ND - 1));

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_character = r_char;
    assign o_last_char = r_last;

    // add 3 to every bcd digit of five or more
    always_comb begin
        for (int d = 0; d < ND; d++) begin
            if (r_bcd[4*d +: 4] >= ADD3_MIN) begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4] + ADD3_VAL;
            end else begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_started <= 1'b0;
            r_cnt     <= '0;
            r_dig     <= '0;
        end else begin
            r_state   <= n_state;
            r_ovalid  <= n_ovalid;
            r_started <= n_started;
            r_cnt     <= n_cnt;
            r_dig     <= n_dig;
        end
        r_mag  <= n_mag;
        r_bcd  <= n_bcd;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    always_comb begin
        n_state   = r_state;
        n_mag     = r_mag;
        n_bcd     = r_bcd;
        n_cnt     = r_cnt;
        n_dig     = r_dig;
        n_neg     = r_neg;
        n_started = r_started;
        n_char    = r_char;
        n_last    = r_last;
        n_ovalid  = r_ovalid && i_stall;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_neg   = i_value[VALUE_BITS-1];
                    n_mag   = i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd = {w_adj[BW-2:0], r_mag[VALUE_BITS-1]};
                n_mag = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(VALUE_BITS - 1)) begin
                    n_dig     = '0;
                    n_started = 1'b0;
                    n_state   = r_neg ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN: begin
                if (w_free) begin
                    n_ovalid = 1'b1;
                    n_char   = MINUS_CHAR;
                    n_last   = 1'b0;
                    n_state  = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (w_top != 4'd0 || r_started || w_is_last) begin
                    if (w_free) begin
                        n_ovalid  = 1'b1;
                        n_char    = DIGIT_BASE + {3'b000, w_top};
                        n_last    = w_is_last;
                        n_started = 1'b1;
                        n_bcd     = {r_bcd[BW-5:0], 4'd0};
                        n_dig     = r_dig + 1'b1;
                        if (w_is_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end else begin
                    // leading zero, skipped
                    n_bcd = {r_bcd[BW-5:0], 4'd0};
                    n_dig = r_dig + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_char == MINUS_CHAR ||
                      (r_char >= DIGIT_BASE && r_char <= DIGIT_BASE + {3'b000, DIGIT_MAX})))
        else $error("output character is neither minus nor digit");

    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_last) |-> (r_char != MINUS_CHAR))
        else $error("text ends on a minus sign");

    a_sign_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SIGN) |-> r_neg)
        else $error("sign emitted for non-negative item");

    a_accept_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_CONV && r_cnt == '0))
        else $error("accepted item did not start conversion");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |=> (r_ovalid && $stable(r_char) && $stable(r_last)))
        else $error("stalled output item changed");

endmodule

`default_nettype wire

[bench/tb_int_to_decimal_ascii_unit.sv]
// testbench for int_to_decimal_ascii_unit: sends signed integers, predicts their decimal text
// and checks every character and the last flag, with random bursts on input and stalls on output
// depends on itda_pkg and int_to_decimal_ascii_unit
`timescale 1ns / 1ps

module tb_int_to_decimal_ascii_unit
    import itda_pkg::*;
;

    localparam int VBITS      = VALUE_BITS_DEF;
    localparam int IDLE_LIMIT = 4000;
    localparam int TAIL_WAIT  = 2 * VBITS;

    typedef struct packed {
        logic [CHAR_BITS-1:0] ch;
        logic                 last;
    } t_text_char;

    typedef enum int {
        RX_FREE,
        RX_HOLD,
        RX_JITTER
    } t_rx_mode;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic [VBITS-1:0]     i_value = '0;
    logic                 i_stall = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [CHAR_BITS-1:0] o_character;
    logic                 o_last_char;

    t_text_char expected_text[$];
    t_text_char head_char;
    int         errors     = 0;
    int         burst_left = 0;
    int         idle_cycles = 0;
    int         stall_left = 0;
    t_rx_mode   stall_mode = RX_FREE;

    int_to_decimal_ascii_unit #(
        .VALUE_BITS(VBITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_character(o_character),
        .o_last_char(o_last_char)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // decimal text of one value, sign first, magnitude taken unsigned
    function automatic void predict_text(input logic [VBITS-1:0] v);
        logic [VBITS-1:0] mag;
        logic [3:0]       digits[$];
        t_text_char       c;
        mag = v[VBITS-1] ? (~v + 1'b1) : v;
        if (mag == '0) begin
            digits.push_front(4'd0);
        end
        while (mag != '0) begin
            digits.push_front(4'(mag % 10));
            mag = mag / 10;
        end
        if (v[VBITS-1]) begin
            c.ch   = MINUS_CHAR;
            c.last = 1'b0;
            expected_text = {expected_text, c};
        end
        for (int i = 0; i < digits.size(); i++) begin
            c.ch   = DIGIT_BASE + {3'b000, digits[i]};
            c.last = (i == digits.size() - 1);
            expected_text = {expected_text, c};
        end
    endfunction

    // one item, sent in bursts with random gaps in between
    task automatic send_value(input logic [VBITS-1:0] v);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (o_stall);
        predict_text(v);
        burst_left--;
    endtask

    task automatic test_sign_and_range();
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'h8000_0001);
        send_value(32'h8000_0000);
        send_value(32'd0);
    endtask

    task automatic test_digit_boundaries();
        send_value(32'd9);
        send_value(32'd10);
        send_value(-32'sd9);
        send_value(-32'sd10);
        send_value(32'd99);
        send_value(32'd100);
        send_value(32'd999_999_999);
        send_value(32'd1_000_000_000);
        send_value(-32'sd1_000_000_000);
        send_value(32'd1_234_567_890);
        send_value(-32'sd987_654_321);
    endtask

    // mostly magnitudes of random bit length so every digit count turns up
    task automatic test_random_values();
        logic [VBITS-1:0] v;
        int               nbits;
        for (int n = 0; n < 350; n++) begin
            if ($urandom_range(0, 4) < 2) begin
                v = $urandom;
            end else begin
                nbits = $urandom_range(1, VBITS - 1);
                v = $urandom & ((32'd1 << nbits) - 1);
                if ($urandom_range(0, 1) == 1) begin
                    v = ~v + 1'b1;
                end
            end
            send_value(v);
        end
    endtask

    // output stall in segments: free, held, or jittering
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = t_rx_mode'($urandom_range(0, 2));
                stall_left = (stall_mode == RX_HOLD) ? $urandom_range(1, 6)
                                                     : $urandom_range(1, 40);
            end
            stall_left--;
            case (stall_mode)
                RX_FREE: i_stall <= 1'b0;
                RX_HOLD: i_stall <= 1'b1;
                default: i_stall <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_text.size() == 0) begin
                $error("unexpected character %0d, last_char %0b", o_character, o_last_char);
                errors++;
            end else begin
                head_char = expected_text.pop_front();
                if (o_character !== head_char.ch) begin
                    $error("character: expected %0d, got %0d", head_char.ch, o_character);
                    errors++;
                end
                if (o_last_char !== head_char.last) begin
                    $error("last_char: expected %0b, got %0b", head_char.last, o_last_char);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_sign_and_range();
        test_digit_boundaries();
        test_random_values();
        @(posedge i_clk);
        i_valid <= 1'b0;
        while (expected_text.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
